@@ hdl/hmvn_pkg.sv @@
// Shared types, constants and state encodings for the heightmap vertex normal block.
`default_nettype none

package hmvn_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int FW            = 36;

    localparam logic [10:0] MAP_WIDTH_RST    = 11'd256;
    localparam logic [15:0] MAP_HEIGHT_RST   = 16'd256;
    localparam logic [15:0] GRID_SPACING_RST = 16'd16;

    localparam logic signed [15:0] ONE_Q15 = 16'sh7fff;

    typedef enum logic [1:0] {
        CFG_MAP_WIDTH    = 2'd0,
        CFG_MAP_HEIGHT   = 2'd1,
        CFG_GRID_SPACING = 2'd2
    } t_cfg_idx;

    typedef logic signed [FW-1:0] t_comp;

    typedef struct packed {
        t_comp x;
        t_comp y;
        t_comp z;
    } t_vec;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_nvec;

    typedef enum logic [3:0] {
        S_IDLE,
        S_STORE,
        S_RD0,
        S_RD1,
        S_MUL,
        S_SUM,
        S_NRM1,
        S_OUT1,
        S_NRM2,
        S_OUT2
    } t_state;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_PREP,
        N_DIV,
        N_DONE
    } t_nstate;

endpackage

`default_nettype wire

@@ hdl/hmvn_in_if.sv @@
// Sample channel: one height per item.
`default_nettype none

interface hmvn_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] height;

    modport source(output valid, output height, input ready);
    modport sink(input valid, input height, output ready);
endinterface

`default_nettype wire

@@ hdl/hmvn_out_if.sv @@
// Normal channel: one unit vertex normal per item.
`default_nettype none

interface hmvn_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [9:0]         vertex_col;
    logic [15:0]        vertex_row;
    logic               last;

    modport source(output valid, output normal_x, output normal_y, output normal_z,
                   output vertex_col, output vertex_row, output last, input ready);
    modport sink(input valid, input normal_x, input normal_y, input normal_z,
                 input vertex_col, input vertex_row, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/hmvn_rows.sv @@
// Row stores: previous row of heights and previous row of face vectors.
`default_nettype none

module hmvn_rows import hmvn_pkg::*; #(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_h_we,
    input  wire logic [AW-1:0] i_h_waddr,
    input  wire logic [15:0]   i_h_wdata,
    input  wire logic [AW-1:0] i_h_raddr,
    output logic [15:0]        o_h_rdata,
    input  wire logic          i_f_we,
    input  wire logic [AW-1:0] i_f_waddr,
    input  wire t_vec          i_f_wdata,
    input  wire logic [AW-1:0] i_f_raddr,
    output t_vec               o_f_rdata
);

    logic [15:0] r_hmem [DEPTH];
    t_vec        r_fmem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_h_we) begin
            r_hmem[i_h_waddr] <= i_h_wdata;
        end
        o_h_rdata <= r_hmem[i_h_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_f_we) begin
            r_fmem[i_f_waddr] <= i_f_wdata;
        end
        o_f_rdata <= r_fmem[i_f_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/hmvn_norm.sv @@
// Normaliser: scales a summed face vector to a unit vector with a bit-serial root and divide.
`default_nettype none

module hmvn_norm import hmvn_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_vec i_vec,
    output logic      o_done,
    output t_nvec     o_nvec
);

    t_nstate r_state, n_state;

    logic [4:0]    r_cnt;
    logic [2:0]    r_neg;
    logic [FW-1:0] r_mag [3];
    logic [63:0]   r_v;
    logic [63:0]   r_res;
    logic [63:0]   r_bit;
    logic [31:0]   r_len;
    logic [47:0]   r_rem [3];
    logic [47:0]   r_dsh;
    logic [15:0]   r_q [3];

    t_comp              w_comp [3];
    logic [FW-1:0]      w_or;
    logic [2:0]         w_sh;
    logic [30:0]        w_msel;
    logic [61:0]        w_sq;
    logic [63:0]        w_trial;
    logic signed [15:0] w_res [3];

    always_comb begin
        w_comp[0] = i_vec.x;
        w_comp[1] = i_vec.y;
        w_comp[2] = i_vec.z;
        w_or      = r_mag[0] | r_mag[1] | r_mag[2];
        // Common right shift that brings the largest magnitude below 2^31.
        priority if (w_or[FW-1]) w_sh = 3'd5;
        else if (w_or[FW-2])     w_sh = 3'd4;
        else if (w_or[FW-3])     w_sh = 3'd3;
        else if (w_or[FW-4])     w_sh = 3'd2;
        else if (w_or[FW-5])     w_sh = 3'd1;
        else                     w_sh = 3'd0;
        w_msel  = r_mag[r_cnt[1:0]][30:0];
        w_sq    = w_msel * w_msel;
        w_trial = r_res + r_bit;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            N_IDLE:  if (i_start) n_state = N_SHIFT;
            N_SHIFT: n_state = N_SQ;
            N_SQ:    if (r_cnt == 5'd2) n_state = N_SQRT;
            N_SQRT:  if (r_cnt == 5'd31) n_state = N_PREP;
            N_PREP:  n_state = N_DIV;
            N_DIV:   if (r_cnt == 5'd15) n_state = N_DONE;
            N_DONE:  n_state = N_IDLE;
            default: n_state = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            N_IDLE: begin
                if (i_start) begin
                    for (int k = 0; k < 3; k++) begin
                        r_neg[k] <= w_comp[k][FW-1];
                        r_mag[k] <= w_comp[k][FW-1] ? FW'(-w_comp[k]) : FW'(w_comp[k]);
                    end
                end
            end
            N_SHIFT: begin
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= r_mag[k] >> w_sh;
                end
                r_v   <= '0;
                r_res <= '0;
                r_bit <= 64'd1 << 62;
                r_cnt <= '0;
            end
            N_SQ: begin
                r_v   <= r_v + 64'(w_sq);
                r_cnt <= (r_cnt == 5'd2) ? 5'd0 : r_cnt + 5'd1;
            end
            N_SQRT: begin
                if (r_v >= w_trial) begin
                    r_v   <= r_v - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
            end
            N_PREP: begin
                // Quotient is (m*65536 + L) / (2L); the first trial divisor is 2L << 15.
                r_len <= r_res[31:0];
                for (int k = 0; k < 3; k++) begin
                    r_rem[k] <= {1'b0, r_mag[k][30:0], 16'd0} + 48'(r_res[31:0]);
                    r_q[k]   <= '0;
                end
                r_dsh <= {r_res[31:0], 16'd0};
                r_cnt <= '0;
            end
            N_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[k] >= r_dsh) begin
                        r_rem[k] <= r_rem[k] - r_dsh;
                        r_q[k]   <= {r_q[k][14:0], 1'b1};
                    end else begin
                        r_q[k]   <= {r_q[k][14:0], 1'b0};
                    end
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 5'd1;
            end
            N_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_done = (r_state == N_DONE);
        for (int k = 0; k < 3; k++) begin
            // A component never exceeds the length, so the quotient is at most 32768.
            if (r_neg[k]) begin
                w_res[k] = $signed(~r_q[k] + 16'd1);
            end else if (r_q[k][15]) begin
                w_res[k] = ONE_Q15;
            end else begin
                w_res[k] = $signed(r_q[k]);
            end
        end
        if (r_len == 32'd0) begin
            o_nvec = '{x: 16'sd0, y: ONE_Q15, z: 16'sd0};
        end else begin
            o_nvec = '{x: w_res[0], y: w_res[1], z: w_res[2]};
        end
    end

endmodule

`default_nettype wire

@@ hdl/heightmap_vertex_normals.sv @@
// Top level: streams heightmap samples in and unit vertex normals out.
// Heights enter on i_smp in raster order, map_width samples per row and
// map_height rows per map. The first row of a map gives no normal. Every
// later sample gives the normal of the vertex one row above it, and on the
// last row each sample also gives the normal of its own vertex right after.
// The o_nrm item flagged last closes the map.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce. A write takes effect at once.
// The normaliser runs a 32-step square root followed by a 16-step divide,
// with the three components divided side by side. Row reads and writes
// go through two-port synchronous stores with registered reads.
// A finished normal waits in an output register, so the next sample is
// taken while the receiver stalls; a second normal waits until it drains.
// Reset restores the register defaults and starts a new map at row and
// column zero; the row stores are not cleared and need no clearing pass.
`default_nettype none

module heightmap_vertex_normals import hmvn_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    hmvn_in_if.sink          i_smp,
    hmvn_out_if.source       o_nrm
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = AW + 1;

    t_state r_state, n_state;

    logic [10:0]   r_map_width;
    logic [15:0]   r_map_height;
    logic [15:0]   r_spacing;
    logic [AW-1:0] r_col;
    logic [15:0]   r_row;

    logic [AW-1:0] r_c;
    logic [15:0]   r_r;
    logic [15:0]   r_h;
    logic          r_lastcol;
    logic          r_lastrow;
    logic [15:0]   r_h1;
    t_vec          r_fl;
    t_vec          r_fc;
    t_vec          r_cur;
    t_vec          r_left;
    t_vec          r_acc;
    t_vec          r_own;

    logic               r_ovalid;
    logic signed [15:0] r_onx;
    logic signed [15:0] r_ony;
    logic signed [15:0] r_onz;
    logic [9:0]         r_ocol;
    logic [15:0]        r_orow;
    logic               r_olast;

    logic [WW-1:0] w_weff;
    logic [15:0]   w_heff;
    logic [AW-1:0] w_c;
    logic [15:0]   w_r;
    logic          w_lastcol;
    logic          w_lastrow;
    logic          w_ready;
    logic          w_slot;
    logic          w_load;
    logic          w_h_we;
    logic          w_f_we;
    logic [AW-1:0] w_h_raddr;
    logic [AW-1:0] w_f_raddr;
    logic [15:0]   w_hrd;
    t_vec          w_frd;
    logic          w_start;
    t_vec          w_nvec_in;
    logic          w_ndone;
    t_nvec         w_nvec;

    logic signed [16:0] w_sp;
    logic signed [16:0] w_dx;
    logic signed [16:0] w_dz;
    logic signed [33:0] w_px;
    logic signed [33:0] w_pz;
    logic [31:0]        w_py;
    logic               w_use_prev;
    logic               w_use_left;

    function automatic t_comp pick(input logic en, input t_comp v);
        return en ? v : '0;
    endfunction

    hmvn_rows #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_rows (
        .i_clk     (i_clk),
        .i_h_we    (w_h_we),
        .i_h_waddr (r_c),
        .i_h_wdata (r_h),
        .i_h_raddr (w_h_raddr),
        .o_h_rdata (w_hrd),
        .i_f_we    (w_f_we),
        .i_f_waddr (r_c - AW'(1)),
        .i_f_wdata (r_left),
        .i_f_raddr (w_f_raddr),
        .o_f_rdata (w_frd)
    );

    hmvn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_vec   (w_nvec_in),
        .o_done  (w_ndone),
        .o_nvec  (w_nvec)
    );

    // Effective geometry and the position of the next sample.
    always_comb begin
        if (32'(r_map_width) > MAX_WIDTH) begin
            w_weff = WW'(MAX_WIDTH);
        end else if (r_map_width < 11'd2) begin
            w_weff = WW'(2);
        end else begin
            w_weff = WW'(r_map_width);
        end
        w_heff = (r_map_height < 16'd2) ? 16'd2 : r_map_height;

        w_c = r_col;
        w_r = r_row;
        if ({1'b0, r_col} >= w_weff) begin
            w_c = '0;
            w_r = r_row + 16'd1;
        end
        if (w_r >= w_heff) begin
            w_r = '0;
        end
        w_lastcol = ({1'b0, w_c} == w_weff - WW'(1));
        w_lastrow = (w_r == w_heff - 16'd1);
    end

    // Face vector of the cell to the right of and below the previous-row vertex.
    always_comb begin
        w_sp       = $signed({1'b0, r_spacing});
        w_dx       = $signed({1'b0, r_h1}) - $signed({1'b0, w_hrd});
        w_dz       = $signed({1'b0, r_h1}) - $signed({1'b0, r_h});
        w_px       = w_dx * w_sp;
        w_pz       = w_dz * w_sp;
        w_py       = r_spacing * r_spacing;
        w_use_prev = (r_r >= 16'd2);
        w_use_left = (r_c != '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_smp.valid) n_state = (w_r == '0) ? S_STORE : S_RD0;
            S_STORE: n_state = S_IDLE;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_NRM1;
            S_NRM1:  if (w_ndone) n_state = S_OUT1;
            S_OUT1:  if (w_slot) n_state = r_lastrow ? S_NRM2 : S_IDLE;
            S_NRM2:  if (w_ndone) n_state = S_OUT2;
            S_OUT2:  if (w_slot) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_slot    = !r_ovalid || o_nrm.ready;
        w_ready   = 1'b0;
        w_h_raddr = r_c;
        w_f_raddr = r_c - AW'(1);
        w_h_we    = 1'b0;
        w_f_we    = 1'b0;
        w_start   = 1'b0;
        w_nvec_in = r_acc;
        w_load    = 1'b0;
        unique case (r_state)
            S_IDLE:  w_ready = 1'b1;
            S_STORE: w_h_we = 1'b1;
            S_RD0: begin
            end
            S_RD1: begin
                w_h_raddr = r_c + AW'(1);
                w_f_raddr = r_c;
            end
            S_MUL: begin
            end
            S_SUM: begin
                w_h_we = 1'b1;
                w_f_we = w_use_left;
            end
            S_NRM1:  w_start = 1'b1;
            S_OUT1:  w_load = w_slot;
            S_NRM2: begin
                w_start   = 1'b1;
                w_nvec_in = r_own;
            end
            S_OUT2:  w_load = w_slot;
            default: begin
            end
        endcase
    end

    assign i_smp.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_map_width  <= MAP_WIDTH_RST;
            r_map_height <= MAP_HEIGHT_RST;
            r_spacing    <= GRID_SPACING_RST;
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAP_WIDTH:    r_map_width  <= i_cfg_data[10:0];
                    CFG_MAP_HEIGHT:   r_map_height <= i_cfg_data;
                    CFG_GRID_SPACING: r_spacing    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == S_STORE || r_state == S_SUM) begin
                if (r_lastcol) begin
                    r_col <= '0;
                    r_row <= r_lastrow ? 16'd0 : r_r + 16'd1;
                end else begin
                    r_col <= r_c + AW'(1);
                    r_row <= r_r;
                end
            end
            if (r_state == S_SUM) begin
                r_left <= r_cur;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (o_nrm.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_smp.valid) begin
            r_c       <= w_c;
            r_r       <= w_r;
            r_h       <= i_smp.height;
            r_lastcol <= w_lastcol;
            r_lastrow <= w_lastrow;
        end
        if (r_state == S_RD1) begin
            r_h1 <= w_hrd;
            r_fl <= w_frd;
        end
        if (r_state == S_MUL) begin
            r_fc <= w_frd;
            if (r_lastcol) begin
                r_cur <= '0;
            end else begin
                r_cur.x <= FW'(w_px);
                r_cur.y <= $signed({4'd0, w_py});
                r_cur.z <= FW'(w_pz);
            end
        end
        if (r_state == S_SUM) begin
            r_acc.x <= pick(w_use_prev && w_use_left, r_fl.x)
                     + pick(w_use_prev && !r_lastcol, r_fc.x)
                     + pick(w_use_left, r_left.x) + r_cur.x;
            r_acc.y <= pick(w_use_prev && w_use_left, r_fl.y)
                     + pick(w_use_prev && !r_lastcol, r_fc.y)
                     + pick(w_use_left, r_left.y) + r_cur.y;
            r_acc.z <= pick(w_use_prev && w_use_left, r_fl.z)
                     + pick(w_use_prev && !r_lastcol, r_fc.z)
                     + pick(w_use_left, r_left.z) + r_cur.z;
            r_own.x <= pick(w_use_left, r_left.x) + r_cur.x;
            r_own.y <= pick(w_use_left, r_left.y) + r_cur.y;
            r_own.z <= pick(w_use_left, r_left.z) + r_cur.z;
        end
        if (w_load) begin
            r_onx   <= w_nvec.x;
            r_ony   <= w_nvec.y;
            r_onz   <= w_nvec.z;
            r_ocol  <= 10'(r_c);
            r_orow  <= (r_state == S_OUT1) ? r_r - 16'd1 : r_r;
            r_olast <= (r_state == S_OUT2) && r_lastcol;
        end
    end

    assign o_nrm.valid      = r_ovalid;
    assign o_nrm.normal_x   = r_onx;
    assign o_nrm.normal_y   = r_ony;
    assign o_nrm.normal_z   = r_onz;
    assign o_nrm.vertex_col = r_ocol;
    assign o_nrm.vertex_row = r_orow;
    assign o_nrm.last       = r_olast;

endmodule

`default_nettype wire

@@ dv/tb_heightmap_vertex_normals.sv @@
// Self-checking testbench for heightmap_vertex_normals: directed and random maps against a predictor.
`default_nettype none

module tb_heightmap_vertex_normals;
    import hmvn_pkg::*;

    localparam int MAXW       = 1024;
    localparam int DRAIN      = 150;
    localparam int STALL_STOP = 20000;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [9:0]         col;
        logic [15:0]        row;
        logic               last;
    } vertex_normal_t;

    // One row of the directed table: a register write or a height sample.
    // A set flat bit means every normal the sample gives points straight up.
    typedef struct packed {
        bit          is_cfg;
        logic [1:0]  idx;
        logic [15:0] val;
        bit          flat;
    } step_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    hmvn_in_if  smp();
    hmvn_out_if nrm();

    heightmap_vertex_normals dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp),
        .o_nrm      (nrm)
    );

    // Predictor copy of the block's registers and row stores.
    logic [10:0] pred_width;
    logic [15:0] pred_height;
    logic [15:0] pred_spacing;
    logic [15:0] row_heights [MAXW];
    longint      row_faces [MAXW][3];
    longint      left_face [3];
    int unsigned next_col;
    int unsigned next_row;

    vertex_normal_t normals_due [$];
    int  fail_count;
    int  heights_sent;
    int  normals_seen;
    int  maps_done;
    int  quiet_cycles;
    bit  calm;
    bit  pending;
    int  ready_hold;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 150);
    endfunction

    function automatic vertex_normal_t unit_normal(longint v0, longint v1, longint v2,
                                                   int unsigned col, int unsigned row,
                                                   bit last);
        longint         v [3];
        bit [63:0]      mag [3];
        bit             neg [3];
        bit [63:0]      mx, l2, rem, res, b, q;
        logic [15:0]    comp [3];
        vertex_normal_t o;
        v = '{v0, v1, v2};
        for (int k = 0; k < 3; k++) begin
            neg[k] = v[k] < 0;
            mag[k] = neg[k] ? 64'(-v[k]) : 64'(v[k]);
        end
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            for (int k = 0; k < 3; k++) mag[k] = mag[k] >> 1;
        end
        l2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        // Bitwise integer square root.
        rem = l2;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        for (int k = 0; k < 3; k++) begin
            if (res == 0) begin
                comp[k] = (k == 1) ? ONE_Q15 : 16'd0;
            end else begin
                q = ((mag[k] << 16) + res) / (2 * res);
                if (neg[k]) begin
                    if (q > 32768) q = 32768;
                    comp[k] = 16'(64'h10000 - q);
                end else begin
                    if (q > 32767) q = 32767;
                    comp[k] = 16'(q);
                end
            end
        end
        o.nx = comp[0];
        o.ny = comp[1];
        o.nz = comp[2];
        o.col = 10'(col);
        o.row = 16'(row);
        o.last = last;
        return o;
    endfunction

    function automatic void predict_normals(logic [15:0] h);
        int unsigned w, ht, c, r;
        longint      s;
        longint      cur [3];
        longint      acc [3];
        longint      own [3];
        bit          lastcol, lastrow, right;
        w = pred_width;
        ht = pred_height;
        s = pred_spacing;
        cur = '{0, 0, 0};
        if (w < 2) w = 2;
        if (w > MAXW) w = MAXW;
        if (ht < 2) ht = 2;
        c = next_col;
        r = next_row;
        if (c >= w) begin
            c = 0;
            r++;
        end
        if (r >= ht) r = 0;
        lastcol = (c == w - 1);
        lastrow = (r == ht - 1);
        right = (c < w - 1);
        if (r >= 1) begin
            acc = '{0, 0, 0};
            own = '{0, 0, 0};
            if (right) begin
                cur[0] = s * (longint'(row_heights[c]) - longint'(row_heights[c + 1]));
                cur[1] = s * s;
                cur[2] = s * (longint'(row_heights[c]) - longint'(h));
            end
            for (int k = 0; k < 3; k++) begin
                if (r >= 2 && c >= 1) acc[k] += row_faces[c - 1][k];
                if (r >= 2 && right) acc[k] += row_faces[c][k];
                if (c >= 1) own[k] += left_face[k];
                if (right) own[k] += cur[k];
                acc[k] += own[k];
            end
            normals_due.push_back(unit_normal(acc[0], acc[1], acc[2], c, r - 1, 1'b0));
            if (lastrow)
                normals_due.push_back(unit_normal(own[0], own[1], own[2], c, r, lastcol));
            if (c >= 1) row_faces[c - 1] = left_face;
            left_face = cur;
        end
        row_heights[c] = h;
        if (lastcol) begin
            next_col = 0;
            next_row = lastrow ? 0 : r + 1;
            if (lastrow) maps_done++;
        end else begin
            next_col = c + 1;
            next_row = r;
        end
    endfunction

    // Offers one height, waits for it to be taken, then predicts its normals.
    task automatic send_height(logic [15:0] h, bit flat);
        int gap;
        int first;
        gap = pick_gap();
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.height <= h;
        do @(posedge i_clk); while (!smp.ready);
        first = normals_due.size();
        predict_normals(h);
        if (flat) begin
            for (int i = first; i < normals_due.size(); i++) begin
                normals_due[i].nx = 16'sd0;
                normals_due[i].ny = ONE_Q15;
                normals_due[i].nz = 16'sd0;
            end
        end
        heights_sent++;
        pending = 1'b1;
    endtask

    task automatic wait_idle();
        smp.valid <= 1'b0;
        if (pending) begin
            @(posedge i_clk);
            while (normals_due.size() != 0) @(posedge i_clk);
            repeat (DRAIN) @(posedge i_clk);
            pending = 1'b0;
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MAP_WIDTH:    pred_width = val[10:0];
            CFG_MAP_HEIGHT:   pred_height = val;
            CFG_GRID_SPACING: pred_spacing = val;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] next_height(int mode, logic [15:0] prev);
        case (mode)
            0: return 16'($urandom);
            1: return prev + 16'($urandom_range(0, 64)) - 16'd32;
            2: return prev;
            default: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        endcase
    endfunction

    task automatic send_rows(int count);
        int mode;
        logic [15:0] h;
        mode = $urandom_range(0, 5);
        if (mode > 3) mode = 1;
        h = 16'($urandom);
        for (int i = 0; i < count; i++) begin
            h = next_height(mode, h);
            send_height(h, 1'b0);
        end
    endtask

    function automatic logic [15:0] pick_spacing();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'd0;
        if (r < 4) return 16'($urandom);
        return 16'($urandom_range(1, 64));
    endfunction

    // Receiver: random stalls, with calm phases where it never stalls.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            nrm.ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else begin
            nrm.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) ready_hold <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        vertex_normal_t e;
        if (i_rst_n && nrm.valid && nrm.ready) begin
            normals_seen++;
            if (normals_due.size() == 0) begin
                $error("normal item at vertex (%0d,%0d) with none expected",
                       nrm.vertex_row, nrm.vertex_col);
                fail_count++;
            end else begin
                e = normals_due.pop_front();
                if (nrm.normal_x !== e.nx) begin
                    $error("normal_x: expected %0d, got %0d", e.nx, nrm.normal_x);
                    fail_count++;
                end
                if (nrm.normal_y !== e.ny) begin
                    $error("normal_y: expected %0d, got %0d", e.ny, nrm.normal_y);
                    fail_count++;
                end
                if (nrm.normal_z !== e.nz) begin
                    $error("normal_z: expected %0d, got %0d", e.nz, nrm.normal_z);
                    fail_count++;
                end
                if (nrm.vertex_col !== e.col) begin
                    $error("vertex_col: expected %0d, got %0d", e.col, nrm.vertex_col);
                    fail_count++;
                end
                if (nrm.vertex_row !== e.row) begin
                    $error("vertex_row: expected %0d, got %0d", e.row, nrm.vertex_row);
                    fail_count++;
                end
                if (nrm.last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, nrm.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((smp.valid && smp.ready) || (nrm.valid && nrm.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_STOP) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        step_row_t steps [$];
        int        rand_sent;
        int        kind;
        logic [15:0] w;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MAP_WIDTH;
        i_cfg_data = 16'd0;
        smp.valid = 1'b0;
        smp.height = 16'd0;
        nrm.ready = 1'b0;
        ready_hold = 0;
        quiet_cycles = 0;
        fail_count = 0;
        heights_sent = 0;
        normals_seen = 0;
        maps_done = 0;
        calm = 1'b0;
        pending = 1'b0;
        pred_width = MAP_WIDTH_RST;
        pred_height = MAP_HEIGHT_RST;
        pred_spacing = GRID_SPACING_RST;
        foreach (row_heights[i]) row_heights[i] = 16'd0;
        foreach (row_faces[i]) row_faces[i] = '{0, 0, 0};
        left_face = '{0, 0, 0};
        next_col = 0;
        next_row = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Flat ground, then zero spacing: both give a straight-up normal.
        steps.push_back('{1'b1, CFG_MAP_WIDTH, 16'd2, 1'b0});
        steps.push_back('{1'b1, CFG_MAP_HEIGHT, 16'd3, 1'b0});
        steps.push_back('{1'b1, CFG_GRID_SPACING, 16'd16, 1'b0});
        repeat (6) steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'd100, 1'b1});
        steps.push_back('{1'b1, CFG_GRID_SPACING, 16'd0, 1'b0});
        steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'd0, 1'b1});
        steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'hffff, 1'b1});
        steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'hffff, 1'b1});
        steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'd0, 1'b1});
        steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'd12345, 1'b1});
        steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'hffff, 1'b1});
        // Unit spacing against full-scale height steps.
        steps.push_back('{1'b1, CFG_GRID_SPACING, 16'd1, 1'b0});
        steps.push_back('{1'b1, CFG_MAP_WIDTH, 16'd3, 1'b0});
        steps.push_back('{1'b1, CFG_MAP_HEIGHT, 16'd2, 1'b0});
        for (int i = 0; i < 6; i++)
            steps.push_back('{1'b0, CFG_MAP_WIDTH, (i % 2) ? 16'hffff : 16'h0000, 1'b0});
        // Width and height of zero both act as two; spacing at its maximum.
        steps.push_back('{1'b1, CFG_GRID_SPACING, 16'hffff, 1'b0});
        steps.push_back('{1'b1, CFG_MAP_WIDTH, 16'd0, 1'b0});
        steps.push_back('{1'b1, CFG_MAP_HEIGHT, 16'd0, 1'b0});
        steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'hffff, 1'b0});
        steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'h0000, 1'b0});
        steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'h0000, 1'b0});
        steps.push_back('{1'b0, CFG_MAP_WIDTH, 16'hffff, 1'b0});

        foreach (steps[i]) begin
            if (steps[i].is_cfg)
                write_reg(steps[i].idx, steps[i].val);
            else
                send_height(steps[i].val, steps[i].flat);
        end

        write_reg(2'd3, 16'($urandom));

        rand_sent = heights_sent;
        while (heights_sent - rand_sent < 870) begin
            calm = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            write_reg(CFG_GRID_SPACING, pick_spacing());
            if (kind == 0) begin
                // Tallest map cut short: lowering the height starts a new map.
                write_reg(CFG_MAP_WIDTH, 16'd3);
                write_reg(CFG_MAP_HEIGHT, 16'hffff);
                send_rows(12);
                write_reg(CFG_MAP_HEIGHT, 16'd2);
                send_rows(6);
            end else if (kind == 1) begin
                // Narrowing mid-row pushes the remaining samples onto a new row.
                write_reg(CFG_MAP_WIDTH, 16'd8);
                write_reg(CFG_MAP_HEIGHT, 16'd5);
                send_rows(20);
                write_reg(CFG_MAP_WIDTH, 16'd3);
                send_rows(6);
            end else begin
                w = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(2, 10))
                                                : 16'($urandom_range(11, 40));
                if ($urandom_range(0, 19) == 0) w = 16'($urandom_range(0, 1));
                write_reg(CFG_MAP_WIDTH, w);
                write_reg(CFG_MAP_HEIGHT, 16'($urandom_range(2, 6)));
                send_rows(((w < 2) ? 2 : w) * pred_height);
            end
        end
        calm = 1'b0;

        smp.valid <= 1'b0;
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Fed %0d heights over %0d complete maps, including the tallest setting.",
                 heights_sent, maps_done);
        $display("Checked %0d vertex normals field by field.", normals_seen);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
